@@ rtl/zstf_pkg.sv @@
// Package for the zero-sum triplet finder: sizes, item kind codes, sequencer
// state codes and the result struct shared by the engine and the top level.
// No dependencies.
package zstf_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int SUM_BITS   = VALUE_BITS + 2;

    // Kind of an input item.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // Sequencer states of the search engine.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SORT_RD  = 4'd1;  // read key at i
    localparam logic [3:0] ST_SORT_KEY = 4'd2;  // latch key, read store[i-1]
    localparam logic [3:0] ST_SORT_CMP = 4'd3;  // compare store[j-1] with key
    localparam logic [3:0] ST_SORT_WR  = 4'd4;  // write key at j
    localparam logic [3:0] ST_ANCHOR   = 4'd5;  // read anchor value
    localparam logic [3:0] ST_ANC_CHK  = 4'd6;  // latch anchor, stop if positive
    localparam logic [3:0] ST_PAIR     = 4'd7;  // read low value or move anchor
    localparam logic [3:0] ST_RD_HI    = 4'd8;  // latch low value, read high value
    localparam logic [3:0] ST_SUM      = 4'd9;  // compare sum with zero
    localparam logic [3:0] ST_SKIP_HI  = 4'd10; // skip repeats of high value
    localparam logic [3:0] ST_SKIP_LO  = 4'd11; // skip repeats of low value
    localparam logic [3:0] ST_SKIP_AN  = 4'd12; // skip repeated anchors
    localparam logic [3:0] ST_DONE     = 4'd13; // hand the result over

    typedef struct packed {
        logic found;
        logic exhausted;
        logic refused;
        logic signed [VALUE_BITS-1:0] smallest;
        logic signed [VALUE_BITS-1:0] middle;
        logic signed [VALUE_BITS-1:0] largest;
    } result_t;

endpackage

@@ rtl/zstf_engine.sv @@
// Search engine of the zero-sum triplet finder: value store, insertion sort
// and the two-pointer walk, all over one registered read port and one three-value sum.
// Depends on zstf_pkg.
module zstf_engine
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     kind,
    input  logic                     first,
    input  logic [zstf_pkg::VALUE_BITS-1:0] value,
    input  logic                     out_free,
    output logic                     done,
    output zstf_pkg::result_t        result
);

    localparam int VB = zstf_pkg::VALUE_BITS;
    localparam int IB = zstf_pkg::IDX_BITS;
    localparam int CB = zstf_pkg::CNT_BITS;
    localparam int SB = zstf_pkg::SUM_BITS;

    logic signed [VB-1:0] mem [zstf_pkg::MAX_ITEMS];
    logic signed [VB-1:0] rd_data_reg;
    logic [IB-1:0]        rd_addr;
    logic                 wr_en;
    logic [IB-1:0]        wr_addr;
    logic signed [VB-1:0] wr_data;

    logic [3:0]  state_reg, state_next;
    logic [CB-1:0] count_reg, count_next;
    logic        sorted_reg, sorted_next;
    logic        sdone_reg, sdone_next;
    logic [CB-1:0] anc_reg, anc_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [CB-1:0] i_reg, i_next, j_reg, j_next;
    logic signed [VB-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, key_reg, key_next;
    logic signed [SB-1:0] sum;
    zstf_pkg::result_t res_reg, res_next;

    // Data read at rd_addr in a cycle is in rd_data_reg in the next.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // The high value is added straight from the read register.
    assign sum = SB'(a_reg) + SB'(b_reg) + SB'(rd_data_reg);
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= zstf_pkg::ST_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b0;
            sdone_reg  <= 1'b0;
            anc_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
            sdone_reg  <= sdone_next;
            anc_reg    <= anc_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sorted_next = sorted_reg;
        sdone_next  = sdone_reg;
        anc_next    = anc_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        key_next    = key_reg;
        res_next    = res_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[IB-1:0];
        wr_data     = value;
        done        = 1'b0;

        unique case (state_reg)
            zstf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    if (kind == zstf_pkg::KIND_LOAD)
                    begin
                        if (first || count_reg < CB'(zstf_pkg::MAX_ITEMS))
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = first ? '0 : count_reg[IB-1:0];
                            count_next  = first ? CB'(1) : count_reg + CB'(1);
                            sorted_next = 1'b0;
                            sdone_next  = 1'b0;
                        end
                        else
                            res_next.refused = 1'b1;
                        state_next = zstf_pkg::ST_DONE;
                    end
                    else if (!sorted_reg)
                    begin
                        sorted_next = 1'b1;
                        sdone_next  = 1'b0;
                        anc_next    = '0;
                        i_next      = CB'(1);
                        state_next  = zstf_pkg::ST_SORT_RD;
                    end
                    else
                        state_next = zstf_pkg::ST_ANCHOR;
                end
            end

            zstf_pkg::ST_SORT_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    lo_next    = CB'(1);
                    hi_next    = (count_reg != '0) ? count_reg - CB'(1) : '0;
                    state_next = zstf_pkg::ST_ANCHOR;
                end
                else
                begin
                    rd_addr    = i_reg[IB-1:0];
                    j_next     = i_reg;
                    state_next = zstf_pkg::ST_SORT_KEY;
                end
            end

            zstf_pkg::ST_SORT_KEY:
            begin
                key_next   = rd_data_reg;
                rd_addr    = i_reg[IB-1:0] - IB'(1);
                state_next = zstf_pkg::ST_SORT_CMP;
            end

            zstf_pkg::ST_SORT_CMP:
            begin
                // rd_data_reg holds store[j-1]; larger entries move up one place.
                if (rd_data_reg > key_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[IB-1:0];
                    wr_data = rd_data_reg;
                    j_next  = j_reg - CB'(1);
                    if (j_reg == CB'(1))
                        state_next = zstf_pkg::ST_SORT_WR;
                    else
                        rd_addr = j_reg[IB-1:0] - IB'(2);
                end
                else
                    state_next = zstf_pkg::ST_SORT_WR;
            end

            zstf_pkg::ST_SORT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IB-1:0];
                wr_data    = key_reg;
                i_next     = i_reg + CB'(1);
                state_next = zstf_pkg::ST_SORT_RD;
            end

            zstf_pkg::ST_ANCHOR:
            begin
                if (sdone_reg || anc_reg >= count_reg)
                begin
                    sdone_next         = 1'b1;
                    res_next.exhausted = 1'b1;
                    state_next         = zstf_pkg::ST_DONE;
                end
                else
                begin
                    rd_addr    = anc_reg[IB-1:0];
                    state_next = zstf_pkg::ST_ANC_CHK;
                end
            end

            zstf_pkg::ST_ANC_CHK:
            begin
                a_next = rd_data_reg;
                // A positive anchor ends the search for good.
                if (!rd_data_reg[VB-1] && rd_data_reg != '0)
                begin
                    sdone_next         = 1'b1;
                    res_next.exhausted = 1'b1;
                    state_next         = zstf_pkg::ST_DONE;
                end
                else
                    state_next = zstf_pkg::ST_PAIR;
            end

            zstf_pkg::ST_PAIR:
            begin
                if (lo_reg < hi_reg && hi_reg < count_reg)
                begin
                    rd_addr    = lo_reg[IB-1:0];
                    state_next = zstf_pkg::ST_RD_HI;
                end
                else
                begin
                    // Next anchor: read store[anc+1] to compare with the anchor.
                    rd_addr    = anc_reg[IB-1:0] + IB'(1);
                    state_next = zstf_pkg::ST_SKIP_AN;
                end
            end

            zstf_pkg::ST_RD_HI:
            begin
                b_next     = rd_data_reg;
                rd_addr    = hi_reg[IB-1:0];
                state_next = zstf_pkg::ST_SUM;
            end

            zstf_pkg::ST_SUM:
            begin
                if (sum[SB-1])
                begin
                    lo_next    = lo_reg + CB'(1);
                    state_next = zstf_pkg::ST_PAIR;
                end
                else if (sum != '0)
                begin
                    hi_next    = hi_reg - CB'(1);
                    state_next = zstf_pkg::ST_PAIR;
                end
                else
                begin
                    c_next            = rd_data_reg;
                    res_next.found    = 1'b1;
                    res_next.smallest = a_reg;
                    res_next.middle   = b_reg;
                    res_next.largest  = rd_data_reg;
                    // The high entry equals c, so the high pointer moves at least once.
                    hi_next           = hi_reg - CB'(1);
                    if (lo_reg < hi_reg - CB'(1))
                    begin
                        rd_addr    = hi_reg[IB-1:0] - IB'(1);
                        state_next = zstf_pkg::ST_SKIP_HI;
                    end
                    else
                        state_next = zstf_pkg::ST_DONE;
                end
            end

            zstf_pkg::ST_SKIP_HI:
            begin
                if (rd_data_reg == c_reg)
                begin
                    hi_next = hi_reg - CB'(1);
                    if (lo_reg < hi_reg - CB'(1))
                        rd_addr = hi_reg[IB-1:0] - IB'(1);
                    else
                        state_next = zstf_pkg::ST_DONE;
                end
                else
                begin
                    // Low value equals b by construction, so it advances once.
                    lo_next = lo_reg + CB'(1);
                    if (lo_reg + CB'(1) < hi_reg)
                    begin
                        rd_addr    = lo_reg[IB-1:0] + IB'(1);
                        state_next = zstf_pkg::ST_SKIP_LO;
                    end
                    else
                        state_next = zstf_pkg::ST_DONE;
                end
            end

            zstf_pkg::ST_SKIP_LO:
            begin
                if (rd_data_reg == b_reg)
                begin
                    lo_next = lo_reg + CB'(1);
                    if (lo_reg + CB'(1) < hi_reg)
                        rd_addr = lo_reg[IB-1:0] + IB'(1);
                    else
                        state_next = zstf_pkg::ST_DONE;
                end
                else
                    state_next = zstf_pkg::ST_DONE;
            end

            zstf_pkg::ST_SKIP_AN:
            begin
                if (anc_reg + CB'(1) < count_reg && rd_data_reg == a_reg)
                begin
                    anc_next = anc_reg + CB'(1);
                    rd_addr  = anc_reg[IB-1:0] + IB'(2);
                end
                else
                begin
                    anc_next   = anc_reg + CB'(1);
                    lo_next    = anc_reg + CB'(2);
                    hi_next    = (count_reg != '0) ? count_reg - CB'(1) : '0;
                    state_next = zstf_pkg::ST_ANCHOR;
                end
            end

            zstf_pkg::ST_DONE:
            begin
                // The result stays in res_reg until the output register is free.
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = zstf_pkg::ST_IDLE;
                end
            end

            default:
                state_next = zstf_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(zstf_pkg::MAX_ITEMS))
        else $error("stored count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == zstf_pkg::ST_IDLE)
        else $error("item started while the engine is busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({res_reg.found, res_reg.exhausted, res_reg.refused}))
        else $error("more than one result flag");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_reg.found) |-> (SB'(res_reg.smallest) + SB'(res_reg.middle)
            + SB'(res_reg.largest) == '0))
        else $error("reported triplet does not sum to zero");

endmodule

@@ rtl/zero_sum_triplet_finder.sv @@
// Zero-sum triplet finder: top level over zstf_engine, using zstf_pkg. A load's result
// waits in the engine's done state until the output register is free, then is registered;
// a new item is taken only after that hand-over. The first fetch after loads sorts the N
// stored values by insertion sort; a fetch then walks a low and a high pointer per anchor.
// One item is in the engine at a time; a finished result waits in the output register.
// rst_n is asynchronous and active low; it empties the set; store contents are kept.
module zero_sum_triplet_finder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value[15:0]
    input  logic [1:0]  s_tuser,   // kind[0], first[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // smallest[15:0], middle[31:16], largest[47:32]
    output logic [2:0]  m_tuser    // found[0], exhausted[1], refused[2]
);

    logic busy_reg, busy_next;
    logic ovalid_reg, ovalid_next;
    logic start;
    logic done;
    logic out_free;
    zstf_pkg::result_t res;
    zstf_pkg::result_t out_reg;

    // Accept while the engine is idle; a result still waiting on the output
    // side does not hold the input back.
    assign s_tready = !busy_reg;
    assign start    = s_tvalid && s_tready;

    // The engine may hand over a new result when the output register is empty
    // or is being emptied in this cycle.
    assign out_free = !ovalid_reg || m_tready;

    zstf_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .kind     (s_tuser[0]),
        .first    (s_tuser[1]),
        .value    (s_tdata),
        .out_free (out_free),
        .done     (done),
        .result   (res)
    );

    always_comb
    begin
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        if (start)
            busy_next = 1'b1;
        if (done)
        begin
            busy_next   = 1'b0;
            ovalid_next = 1'b1;
        end
        else if (m_tvalid && m_tready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= res;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {out_reg.largest, out_reg.middle, out_reg.smallest};
    assign m_tuser  = {out_reg.refused, out_reg.exhausted, out_reg.found};

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("engine finished without an item in flight");
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("accepted item not tracked");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!ovalid_reg || m_tready))
        else $error("result overwrites a waiting result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("waiting result changed");

endmodule
